### src/spiq_pkg.sv
package spiq_pkg;

    localparam int PRIO_W = 8;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 5;

    typedef logic [1:0] op_code_t;

    typedef enum logic [1:0] {
        OP_PRIO_INSERT = 2'd0,
        OP_TAIL_INSERT = 2'd1,
        OP_POP_FRONT   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [OCC_W-1:0] occ_t;

    typedef struct packed {
        op_code_t          op;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  client_tag;
    } in_t;

    typedef struct packed {
        logic              head_valid;
        logic [PRIO_W-1:0] head_priority;
        logic [TAG_W-1:0]  head_tag;
        occ_t              occupancy;
        logic [1:0]        status;
    } out_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic by_prio;
        logic pop;
    } cell_ctl_t;

endpackage

### src/spiq_cell.sv
module spiq_cell
    import spiq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_used,
    input  logic      left_shift,
    input  entry_t    right_entry,
    input  logic      right_used,
    output logic      shift_out,
    output entry_t    entry,
    output logic      used
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   used_reg;
    logic   used_next;
    logic   gt;
    logic   take_new;

    assign gt        = ctl.ins && ctl.by_prio && used_reg && (entry_reg.prio > new_entry.prio);
    assign shift_out = left_shift || gt;
    assign take_new  = ctl.ins && !left_shift && (gt || (!used_reg && left_used));

    always_comb
    begin
        entry_next = entry_reg;
        used_next  = used_reg;
        if (ctl.pop)
        begin
            entry_next = right_entry;
            used_next  = right_used;
        end
        else if (ctl.ins && left_shift)
        begin
            entry_next = left_entry;
            used_next  = left_used;
        end
        else if (take_new)
        begin
            entry_next = new_entry;
            used_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign used  = used_reg;

endmodule

### src/stable_priority_insert_queue.sv
// Ordered queue of QUEUE_DEPTH entries held in a row of cells that shift in
// parallel. A command transfers when start is high and busy is low; busy stays
// low, so a command can transfer in every cycle. The result of each command
// appears on result with strobe high in the cycle after its transfer, for one
// cycle only, and the receiver cannot stall it. A priority insert goes behind
// all entries of lower or equal priority, a tail insert goes to the back, and a
// pop removes the front. Pop on empty and insert when full change nothing and
// report their status.
module stable_priority_insert_queue
    import spiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic strobe,
    output out_t result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t         cell_entry [QUEUE_DEPTH];
    logic           cell_used  [QUEUE_DEPTH];
    logic           cell_shift [QUEUE_DEPTH];
    entry_t         new_entry;
    cell_ctl_t      ctl;
    logic           accept;
    logic           is_ins;
    logic           is_pop;
    logic           full;
    logic           empty;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic           strobe_reg;
    status_t        status_reg;
    status_t        status_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign is_ins = (cmd.op == OP_PRIO_INSERT) || (cmd.op == OP_TAIL_INSERT);
    assign is_pop = (cmd.op == OP_POP_FRONT);

    assign new_entry.prio = cmd.priority_req;
    assign new_entry.tag  = cmd.client_tag;

    assign ctl.ins     = accept && is_ins && !full;
    assign ctl.by_prio = (cmd.op == OP_PRIO_INSERT);
    assign ctl.pop     = accept && is_pop && !empty;

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (is_ins && full)
        begin
            status_next = ST_FULL;
        end
        else if (is_pop && empty)
        begin
            status_next = ST_EMPTY;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_used;
        logic   left_shift;
        entry_t right_entry;
        logic   right_used;

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_used  = 1'b1;
            assign left_shift = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_used  = cell_used[i-1];
            assign left_shift = cell_shift[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = new_entry;
            assign right_used  = 1'b0;
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
            assign right_used  = cell_used[i+1];
        end

        spiq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_used   (left_used),
            .left_shift  (left_shift),
            .right_entry (right_entry),
            .right_used  (right_used),
            .shift_out   (cell_shift[i]),
            .entry       (cell_entry[i]),
            .used        (cell_used[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= accept;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    assign strobe               = strobe_reg;
    assign result.head_valid    = cell_used[0];
    assign result.head_priority = cell_used[0] ? cell_entry[0].prio : '0;
    assign result.head_tag      = cell_used[0] ? cell_entry[0].tag : '0;
    assign result.occupancy     = occ_t'(count_reg);
    assign result.status        = status_reg;

endmodule

### src/spiq_checker.sv
module spiq_checker
    import spiq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input out_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (strobe == $past(start && !busy)))
        else $error("strobe does not follow the command transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.head_valid == (result.occupancy != '0)))
        else $error("head_valid disagrees with occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.head_valid) |-> (result.head_priority == '0 && result.head_tag == '0))
        else $error("empty queue shows a nonzero head entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.status == ST_EMPTY) |-> (result.occupancy == '0))
        else $error("pop on empty reported with entries present");

endmodule

bind stable_priority_insert_queue spiq_checker u_spiq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
